// File: rtl/cans_pkg.sv
// Package for the chart axis scaler: constants, sequencer codes, unit request types.
`timescale 1ns / 1ps
`default_nettype none

package cans_pkg;

  // Block configuration.
  localparam int MAX_VALUE = 1000000;
  localparam int TICKS     = 6;
  localparam int FRAC_BITS = 8;

  // Field and datapath widths.
  localparam int IN_W  = 29;  // signed fixed-point input fields
  localparam int OUT_W = 20;  // integer result fields
  localparam int QW    = 29;  // non-negative fixed-point range values
  localparam int SW    = 32;  // tick step and divisor
  localparam int NW    = 32;  // target of the nice-step search
  localparam int AW    = 36;  // signed axis bound candidates
  localparam int MQW   = 48;  // wide compare against the fixed-point limit
  localparam int DCNT_W = $clog2(QW);
  localparam int MIDX_W = 4;

  // Derived constants.
  localparam int IV      = TICKS - 1;
  localparam int DEN     = IV << FRAC_BITS;
  localparam int FB_STEP = (MAX_VALUE + IV - 1) / IV;
  localparam logic [QW:0] ONE_Q = (QW+1)'(1) << FRAC_BITS;
  localparam logic signed [MQW-1:0] MAXQ = MQW'(MAX_VALUE) << FRAC_BITS;
  localparam logic signed [AW-1:0] MAX_S = AW'(MAX_VALUE);
  localparam logic [SW-1:0] MAX_STEP = SW'(MAX_VALUE);

  // Padding and step growth constants.
  localparam int PAD_DIV_SPAN = 20;
  localparam int PAD_DIV_HI   = 100;
  localparam int GROW_MIN     = 100;
  localparam int GROW_SCALE   = 100;
  localparam int GROW_DEN     = 50;

  // Padding divisions by reciprocal multiplication. Both divisors are four times an odd
  // factor, so the dividend drops two bits first. Each reciprocal is rounded up, and its
  // error times any 27-bit dividend stays below two to the shift, so the quotient is exact.
  localparam int PAD_PRE    = 2;
  localparam int PAD_X_W    = QW - PAD_PRE;
  localparam int RECIP_W    = 28;
  localparam int PAD_PROD_W = PAD_X_W + RECIP_W;
  localparam int SPAN_SHIFT = 30;
  localparam int HI_SHIFT   = 32;
  localparam logic [RECIP_W-1:0] SPAN_RECIP =
    RECIP_W'(((64'd1 << SPAN_SHIFT) + 64'(PAD_DIV_SPAN >> PAD_PRE) - 64'd1) /
             64'(PAD_DIV_SPAN >> PAD_PRE));
  localparam logic [RECIP_W-1:0] HI_RECIP =
    RECIP_W'(((64'd1 << HI_SHIFT) + 64'(PAD_DIV_HI >> PAD_PRE) - 64'd1) /
             64'(PAD_DIV_HI >> PAD_PRE));

  // Default result for invalid input.
  localparam int DEF_MAX  = 100;
  localparam int DEF_STEP = 20;

  // Mantissa table, held as twice the nice mantissa.
  localparam logic [4:0] MANT_TOP = 5'd20;
  localparam logic [MIDX_W-1:0] MANT_LAST = 4'd9;

  function automatic logic [4:0] mant_half(input logic [MIDX_W-1:0] idx);
    logic [4:0] v;
    case (idx)
      4'd0:    v = 5'd2;
      4'd1:    v = 5'd3;
      4'd2:    v = 5'd4;
      4'd3:    v = 5'd5;
      4'd4:    v = 5'd6;
      4'd5:    v = 5'd8;
      4'd6:    v = 5'd10;
      4'd7:    v = 5'd12;
      4'd8:    v = 5'd16;
      default: v = MANT_TOP;
    endcase
    return v;
  endfunction

  // Main sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PAD,
    ST_CLAMP,
    ST_SPAN,
    ST_NICE,
    ST_LOOP,
    ST_DIV1,
    ST_OVF,
    ST_DIV2,
    ST_FIT,
    ST_GROW,
    ST_DONE
  } cans_state_t;

  // Nice-step search states.
  typedef enum logic [1:0] {
    NS_IDLE,
    NS_DECADE,
    NS_MANT
  } nice_state_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] dividend;
    logic [SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] num;
    logic [NW-1:0] den;
  } nice_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] value;
  } nice_rsp_t;

endpackage

`default_nettype wire

// File: rtl/cans_if.sv
// Valid/ready stream interfaces for the data bounds and the axis scale result.
`timescale 1ns / 1ps
`default_nettype none

interface cans_bounds_if;
  logic                               valid;
  logic                               ready;
  logic signed [cans_pkg::IN_W-1:0]   min_value;
  logic signed [cans_pkg::IN_W-1:0]   max_value;
  logic                               not_finite;

  modport source (output valid, output min_value, output max_value, output not_finite,
                  input ready);
  modport sink (input valid, input min_value, input max_value, input not_finite,
                output ready);
endinterface

interface cans_scale_if;
  logic                        valid;
  logic                        ready;
  logic [cans_pkg::OUT_W-1:0]  axis_min;
  logic [cans_pkg::OUT_W-1:0]  axis_max;
  logic [cans_pkg::OUT_W-1:0]  tick_step;
  logic                        used_default;

  modport source (output valid, output axis_min, output axis_max, output tick_step,
                  output used_default, input ready);
  modport sink (input valid, input axis_min, input axis_max, input tick_step,
                input used_default, output ready);
endinterface

`default_nettype wire

// File: rtl/cans_div.sv
// Shared restoring divider: one quotient bit per cycle, gives the remainder.
`timescale 1ns / 1ps
`default_nettype none

module cans_div (
  input  logic               clk,
  input  logic               rst,
  input  cans_pkg::div_req_t req,
  output cans_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [cans_pkg::DCNT_W-1:0]       cnt;
  logic [cans_pkg::SW-1:0]           rem;
  logic [cans_pkg::QW-1:0]           quo;
  logic [cans_pkg::SW-1:0]           dvs;
  logic [cans_pkg::SW:0]             shifted;
  logic [cans_pkg::SW+1:0]           diff;
  logic                              fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem, quo[cans_pkg::QW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign fits    = !diff[cans_pkg::SW+1];

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= cans_pkg::DCNT_W'(cans_pkg::QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[cans_pkg::SW-1:0] : shifted[cans_pkg::SW-1:0];
      quo <= {quo[cans_pkg::QW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// File: rtl/cans_nice.sv
// Nice-step search: smallest mantissa times a power of ten whose scaled value reaches a target.
`timescale 1ns / 1ps
`default_nettype none

module cans_nice (
  input  logic                clk,
  input  logic                rst,
  input  cans_pkg::nice_req_t req,
  output cans_pkg::nice_rsp_t rsp
);

  cans_pkg::nice_state_t              nstate;
  cans_pkg::nice_state_t              nstate_next;
  logic [cans_pkg::NW-1:0]            num;
  logic [cans_pkg::NW-1:0]            cm;
  logic [cans_pkg::NW-1:0]            m;
  logic [cans_pkg::NW-1:0]            cm10;
  logic [cans_pkg::NW-1:0]            m10;
  logic [cans_pkg::MIDX_W-1:0]        idx;
  logic [4:0]                         half;
  logic [cans_pkg::NW+4:0]            cm20;
  logic [cans_pkg::NW+4:0]            cand;
  logic [cans_pkg::NW+4:0]            twice;
  logic                               need_decade;
  logic                               hit;
  logic                               done;
  logic [cans_pkg::SW-1:0]            value;

  // The decade unit cm is m times the denominator, so one product covers each candidate.
  assign half  = cans_pkg::mant_half(idx);
  assign cm10  = (cm << 3) + (cm << 1);
  assign m10   = (m << 3) + (m << 1);
  assign cm20  = (cans_pkg::NW+5)'(cm) * (cans_pkg::NW+5)'(cans_pkg::MANT_TOP);
  assign cand  = (cans_pkg::NW+5)'(cm) * (cans_pkg::NW+5)'(half);
  assign twice = (cans_pkg::NW+5)'(m) * (cans_pkg::NW+5)'(half) + (cans_pkg::NW+5)'(1);
  assign need_decade = cm20 < (cans_pkg::NW+5)'(num);
  assign hit = (cand >= (cans_pkg::NW+5)'(num)) || (idx == cans_pkg::MANT_LAST);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      nstate <= cans_pkg::NS_IDLE;
    end else begin
      nstate <= nstate_next;
    end
  end

  // Skip whole decades first, then walk the mantissas of the right decade.
  always_comb begin
    nstate_next = nstate;
    unique case (nstate)
      cans_pkg::NS_IDLE: begin
        if (req.start) nstate_next = cans_pkg::NS_DECADE;
      end
      cans_pkg::NS_DECADE: begin
        if (!need_decade) nstate_next = cans_pkg::NS_MANT;
      end
      cans_pkg::NS_MANT: begin
        if (hit) nstate_next = cans_pkg::NS_IDLE;
      end
      default: nstate_next = cans_pkg::NS_IDLE;
    endcase
  end

  // Completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (nstate == cans_pkg::NS_MANT) && hit;
    end
  end

  // Search registers; the result is the candidate rounded up to an integer.
  always_ff @(posedge clk) begin
    case (nstate)
      cans_pkg::NS_IDLE: begin
        if (req.start) begin
          num <= req.num;
          cm  <= req.den;
          m   <= cans_pkg::NW'(1);
          idx <= '0;
        end
      end
      cans_pkg::NS_DECADE: begin
        if (need_decade) begin
          cm <= cm10;
          m  <= m10;
        end
      end
      cans_pkg::NS_MANT: begin
        if (hit) begin
          value <= twice[cans_pkg::SW:1];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

`default_nettype wire

// File: rtl/chart_axis_nice_scale.sv
// Chart axis scaler top level: sequencer, range registers and result register.
// Invalid input goes from the check straight to the default result. Otherwise the range
// is padded and clamped, the nice-step search gives the first step, and each step tried
// runs through the shared divider, each further step through the search first.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Synchronous active-high reset returns the sequencer to idle and drops the output valid.
`timescale 1ns / 1ps
`default_nettype none

module chart_axis_nice_scale (
  input  logic          clk,
  input  logic          rst,
  cans_bounds_if.sink   bounds,
  cans_scale_if.source  scale
);

  cans_pkg::cans_state_t               state;
  cans_pkg::cans_state_t               state_next;
  cans_pkg::div_req_t                  div_req;
  cans_pkg::div_rsp_t                  div_rsp;
  cans_pkg::nice_req_t                 nice_req;
  cans_pkg::nice_rsp_t                 nice_rsp;

  logic signed [cans_pkg::IN_W-1:0]    lo_r;
  logic signed [cans_pkg::IN_W-1:0]    hi_r;
  logic                                nf_r;
  logic                                tiny_span_r;
  logic [cans_pkg::PAD_X_W-1:0]        pad_num;
  logic [cans_pkg::QW-1:0]             pad_q;
  logic [cans_pkg::QW-1:0]             pmin;
  logic [cans_pkg::QW-1:0]             pmax;
  logic [cans_pkg::QW-1:0]             pmin_int;
  logic [cans_pkg::QW-1:0]             pmax_ceil;
  logic [cans_pkg::SW-1:0]             step;
  logic signed [cans_pkg::AW-1:0]      siv;
  logic signed [cans_pkg::AW-1:0]      amin;
  logic signed [cans_pkg::AW-1:0]      amax;
  logic [cans_pkg::OUT_W-1:0]          res_min;
  logic [cans_pkg::OUT_W-1:0]          res_max;
  logic [cans_pkg::OUT_W-1:0]          res_step;
  logic                                res_def;
  logic                                out_valid;
  logic [cans_pkg::OUT_W-1:0]          out_min;
  logic [cans_pkg::OUT_W-1:0]          out_max;
  logic [cans_pkg::OUT_W-1:0]          out_step;
  logic                                out_def;
  logic                                load_out;

  logic signed [cans_pkg::MQW-1:0]     hi_ext;
  logic                                invalid;
  logic [cans_pkg::QW-1:0]             span;
  logic                                tiny_span;
  logic [cans_pkg::RECIP_W-1:0]        pad_recip;
  logic [cans_pkg::PAD_PROD_W-1:0]     pad_prod;
  logic [cans_pkg::QW-1:0]             pad_quot;
  logic [cans_pkg::QW-1:0]             pad;
  logic [cans_pkg::QW-1:0]             pmax_sum;
  logic signed [cans_pkg::MQW-1:0]     pmax_ext;
  logic [cans_pkg::QW:0]               pmax_round;
  logic signed [cans_pkg::AW-1:0]      pmin_int_s;
  logic signed [cans_pkg::AW-1:0]      pmax_ceil_s;
  logic signed [cans_pkg::AW-1:0]      rem_s;
  logic signed [cans_pkg::AW-1:0]      amin_div;
  logic signed [cans_pkg::AW-1:0]      amax_top;
  logic                                fit;
  logic [cans_pkg::NW-1:0]             grow_num;

  cans_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cans_nice u_nice (
    .clk (clk),
    .rst (rst),
    .req (nice_req),
    .rsp (nice_rsp)
  );

  // Input validity and span of the data range.
  assign hi_ext    = cans_pkg::MQW'(hi_r);
  assign invalid   = nf_r || lo_r[cans_pkg::IN_W-1] || (hi_r < lo_r) ||
                     (hi_ext > cans_pkg::MAXQ);
  assign span      = cans_pkg::QW'(hi_r) - cans_pkg::QW'(lo_r);
  assign tiny_span = {1'b0, span} < cans_pkg::ONE_Q;

  // Padding quotient: 5% of the span, or 1% of the maximum for a span below one.
  assign pad_recip = tiny_span_r ? cans_pkg::HI_RECIP : cans_pkg::SPAN_RECIP;
  assign pad_prod  = cans_pkg::PAD_PROD_W'(pad_num) * cans_pkg::PAD_PROD_W'(pad_recip);
  assign pad_quot  = tiny_span_r ? cans_pkg::QW'(pad_prod >> cans_pkg::HI_SHIFT) :
                                   cans_pkg::QW'(pad_prod >> cans_pkg::SPAN_SHIFT);

  // Padding and the clamped padded range.
  always_comb begin
    if (tiny_span_r && (pad_q < cans_pkg::ONE_Q[cans_pkg::QW-1:0])) begin
      pad = cans_pkg::ONE_Q[cans_pkg::QW-1:0];
    end else begin
      pad = pad_q;
    end
  end
  assign pmax_sum   = cans_pkg::QW'(hi_r) + pad;
  assign pmax_ext   = $signed(cans_pkg::MQW'(pmax_sum));
  assign pmax_round = {1'b0, pmax} + (cans_pkg::ONE_Q - (cans_pkg::QW+1)'(1));

  // Axis bound candidates from the divider remainder.
  assign pmin_int_s  = $signed(cans_pkg::AW'(pmin_int));
  assign pmax_ceil_s = $signed(cans_pkg::AW'(pmax_ceil));
  assign rem_s       = $signed(cans_pkg::AW'(div_rsp.rem));
  assign amin_div    = pmin_int_s - rem_s;
  assign amax_top    = cans_pkg::MAX_S - rem_s;

  // Fit test, with both bounds compared as integers.
  assign fit = !amin[cans_pkg::AW-1] && (amin <= pmin_int_s) && (amax >= pmax_ceil_s) &&
               (amax <= cans_pkg::MAX_S);

  // Target for the next step: at least the step plus one percent, and at least one more.
  assign grow_num = cans_pkg::NW'(step) * cans_pkg::NW'(cans_pkg::GROW_SCALE) +
                    ((step > cans_pkg::SW'(cans_pkg::GROW_MIN)) ?
                     cans_pkg::NW'(step) : cans_pkg::NW'(cans_pkg::GROW_MIN));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cans_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and the requests to the divider and the search unit.
  always_comb begin
    state_next = state;
    div_req    = '0;
    nice_req   = '0;
    load_out   = 1'b0;
    unique case (state)
      cans_pkg::ST_IDLE: begin
        if (bounds.valid) state_next = cans_pkg::ST_CHECK;
      end
      cans_pkg::ST_CHECK: begin
        if (invalid) begin
          state_next = cans_pkg::ST_DONE;
        end else begin
          state_next = cans_pkg::ST_PAD;
        end
      end
      cans_pkg::ST_PAD: begin
        state_next = cans_pkg::ST_CLAMP;
      end
      cans_pkg::ST_CLAMP: begin
        state_next = cans_pkg::ST_SPAN;
      end
      cans_pkg::ST_SPAN: begin
        nice_req.start = 1'b1;
        nice_req.num   = cans_pkg::NW'({pmax - pmin, 1'b0});
        nice_req.den   = cans_pkg::NW'(cans_pkg::DEN);
        state_next     = cans_pkg::ST_NICE;
      end
      cans_pkg::ST_NICE: begin
        if (nice_rsp.done) state_next = cans_pkg::ST_LOOP;
      end
      cans_pkg::ST_LOOP: begin
        if (step > cans_pkg::MAX_STEP) begin
          state_next = cans_pkg::ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = pmin_int;
          div_req.divisor  = step;
          state_next       = cans_pkg::ST_DIV1;
        end
      end
      cans_pkg::ST_DIV1: begin
        if (div_rsp.done) state_next = cans_pkg::ST_OVF;
      end
      cans_pkg::ST_OVF: begin
        if (amax > cans_pkg::MAX_S) begin
          div_req.start    = 1'b1;
          div_req.dividend = cans_pkg::QW'(cans_pkg::MAX_VALUE);
          div_req.divisor  = step;
          state_next       = cans_pkg::ST_DIV2;
        end else begin
          state_next = cans_pkg::ST_FIT;
        end
      end
      cans_pkg::ST_DIV2: begin
        if (div_rsp.done) state_next = cans_pkg::ST_FIT;
      end
      cans_pkg::ST_FIT: begin
        if (fit) begin
          state_next = cans_pkg::ST_DONE;
        end else begin
          nice_req.start = 1'b1;
          nice_req.num   = grow_num;
          nice_req.den   = cans_pkg::NW'(cans_pkg::GROW_DEN);
          state_next     = cans_pkg::ST_GROW;
        end
      end
      cans_pkg::ST_GROW: begin
        if (nice_rsp.done) state_next = cans_pkg::ST_LOOP;
      end
      cans_pkg::ST_DONE: begin
        if (!out_valid || scale.ready) begin
          load_out   = 1'b1;
          state_next = cans_pkg::ST_IDLE;
        end
      end
      default: state_next = cans_pkg::ST_IDLE;
    endcase
  end

  // Working registers, loaded as the sequencer moves through the item.
  always_ff @(posedge clk) begin
    case (state)
      cans_pkg::ST_IDLE: begin
        if (bounds.valid) begin
          lo_r <= bounds.min_value;
          hi_r <= bounds.max_value;
          nf_r <= bounds.not_finite;
        end
      end
      cans_pkg::ST_CHECK: begin
        tiny_span_r <= tiny_span;
        pad_num     <= tiny_span ? hi_r[cans_pkg::IN_W-1:cans_pkg::PAD_PRE] :
                                   span[cans_pkg::QW-1:cans_pkg::PAD_PRE];
        if (invalid) begin
          res_min  <= '0;
          res_max  <= cans_pkg::OUT_W'(cans_pkg::DEF_MAX);
          res_step <= cans_pkg::OUT_W'(cans_pkg::DEF_STEP);
          res_def  <= 1'b1;
        end
      end
      cans_pkg::ST_PAD: begin
        pad_q <= pad_quot;
      end
      cans_pkg::ST_CLAMP: begin
        pmin <= (cans_pkg::QW'(lo_r) >= pad) ? cans_pkg::QW'(lo_r) - pad : '0;
        pmax <= (pmax_ext > cans_pkg::MAXQ) ? cans_pkg::MAXQ[cans_pkg::QW-1:0] : pmax_sum;
      end
      cans_pkg::ST_SPAN: begin
        pmin_int  <= pmin >> cans_pkg::FRAC_BITS;
        pmax_ceil <= cans_pkg::QW'(pmax_round >> cans_pkg::FRAC_BITS);
      end
      cans_pkg::ST_NICE, cans_pkg::ST_GROW: begin
        if (nice_rsp.done) step <= nice_rsp.value;
      end
      cans_pkg::ST_LOOP: begin
        siv <= $signed(cans_pkg::AW'(step) * cans_pkg::AW'(cans_pkg::IV));
        if (step > cans_pkg::MAX_STEP) begin
          res_min  <= '0;
          res_max  <= cans_pkg::OUT_W'(cans_pkg::MAX_VALUE);
          res_step <= cans_pkg::OUT_W'(cans_pkg::FB_STEP);
          res_def  <= 1'b0;
        end
      end
      cans_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          amin <= amin_div;
          amax <= amin_div + siv;
        end
      end
      cans_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          amax <= amax_top;
          amin <= amax_top - siv;
        end
      end
      cans_pkg::ST_FIT: begin
        if (fit) begin
          res_min  <= amin[cans_pkg::OUT_W-1:0];
          res_max  <= amax[cans_pkg::OUT_W-1:0];
          res_step <= step[cans_pkg::OUT_W-1:0];
          res_def  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Output register: holds a finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (scale.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_min  <= res_min;
      out_max  <= res_max;
      out_step <= res_step;
      out_def  <= res_def;
    end
  end

  assign bounds.ready       = (state == cans_pkg::ST_IDLE);
  assign scale.valid        = out_valid;
  assign scale.axis_min     = out_min;
  assign scale.axis_max     = out_max;
  assign scale.tick_step    = out_step;
  assign scale.used_default = out_def;

endmodule

`default_nettype wire

// File: rtl/cans_checker.sv
// Port-level assertions for the chart axis scaler and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module cans_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        bounds_valid,
  input wire logic                        bounds_ready,
  input wire logic                        scale_valid,
  input wire logic                        scale_ready,
  input wire logic [cans_pkg::OUT_W-1:0]  axis_min,
  input wire logic [cans_pkg::OUT_W-1:0]  axis_max,
  input wire logic [cans_pkg::OUT_W-1:0]  tick_step,
  input wire logic                        used_default
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !scale_valid)
    else $error("result valid after reset");

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    scale_valid && !scale_ready |=>
      scale_valid && $stable(axis_min) && $stable(axis_max) && $stable(tick_step) &&
      $stable(used_default))
    else $error("pending result changed");

  // The default flag always comes with the default axis.
  a_default: assert property (@(posedge clk) disable iff (rst)
    scale_valid && used_default |->
      axis_min == '0 && axis_max == cans_pkg::OUT_W'(cans_pkg::DEF_MAX) &&
      tick_step == cans_pkg::OUT_W'(cans_pkg::DEF_STEP))
    else $error("default flag with other axis values");

  // A computed axis has a nonzero step and a nonempty range.
  a_axis: assert property (@(posedge clk) disable iff (rst)
    scale_valid && !used_default |-> tick_step != '0 && axis_min < axis_max)
    else $error("malformed axis result");

  // No result can appear in the cycle right after an item is taken.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    bounds_valid && bounds_ready |=> !$rose(scale_valid))
    else $error("result appeared too early");

endmodule

bind chart_axis_nice_scale cans_checker u_cans_checker (
  .clk          (clk),
  .rst          (rst),
  .bounds_valid (bounds.valid),
  .bounds_ready (bounds.ready),
  .scale_valid  (scale.valid),
  .scale_ready  (scale.ready),
  .axis_min     (scale.axis_min),
  .axis_max     (scale.axis_max),
  .tick_step    (scale.tick_step),
  .used_default (scale.used_default)
);

`default_nettype wire

// File: dv/chart_axis_nice_scale_tb.sv
// Self-checking testbench for the chart axis scaler: directed table, random bounds, idle mixes.
`timescale 1ns / 1ps

module chart_axis_nice_scale_tb;

  localparam int     FRAC       = cans_pkg::FRAC_BITS;
  localparam longint AXIS_TOP   = cans_pkg::MAX_VALUE;
  localparam longint INTERVALS  = cans_pkg::TICKS - 1;
  localparam longint ONE_Q      = longint'(1) << FRAC;
  localparam longint MAXQ       = AXIS_TOP << FRAC;
  localparam longint FIELD_TOP  = 268435455;
  localparam int     DIR_N      = 22;
  localparam int     RAND_PER_PHASE = 215;
  localparam int     STALL_LIMIT    = 40000;
  localparam int     DRAIN_CYCLES   = 200;
  localparam int     PRINT_CAP      = 100;

  typedef struct packed {
    logic [cans_pkg::OUT_W-1:0] axis_min;
    logic [cans_pkg::OUT_W-1:0] axis_max;
    logic [cans_pkg::OUT_W-1:0] tick_step;
    logic                       used_default;
  } scale_t;

  typedef struct packed {
    logic signed [cans_pkg::IN_W-1:0] lo;
    logic signed [cans_pkg::IN_W-1:0] hi;
    logic                             nf;
    logic                             typed;
    scale_t                           want;
  } dir_row_t;

  localparam scale_t DEFAULT_SCALE = '{20'd0, 20'd100, 20'd20, 1'b1};
  localparam scale_t FULL_SCALE    = '{20'd0, 20'(cans_pkg::MAX_VALUE), 20'd200000, 1'b0};
  localparam scale_t NONE          = '{20'd0, 20'd0, 20'd0, 1'b0};

  // Twice each nice mantissa, so that 1.5 and 2.5 stay integers.
  localparam longint NICE_TWICE [10] = '{2, 3, 4, 5, 6, 8, 10, 12, 16, 20};

  logic clk;
  logic rst;

  cans_bounds_if bounds_ch ();
  cans_scale_if  scale_ch ();

  chart_axis_nice_scale dut (
    .clk    (clk),
    .rst    (rst),
    .bounds (bounds_ch),
    .scale  (scale_ch)
  );

  scale_t   pending_scales [$];
  dir_row_t dir_rows [DIR_N];
  int       mismatch_count = 0;
  int       src_idle_pct   = 0;
  int       snk_idle_pct   = 0;
  int       quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Smallest integer-rounded nice value that is at least num/den.
  function automatic longint unsigned nice_ceil(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned dec;
    longint unsigned twice;
    int i;
    if (num <= den) return 1;
    for (dec = 1; dec <= 64'd1000000000; dec = dec * 10) begin
      for (i = 0; i < 10; i++) begin
        twice = longint'(NICE_TWICE[i]) * dec;
        if (twice * den >= 2 * num) return (twice + 1) / 2;
      end
    end
    return 64'd10000000000;
  endfunction

  // Expected axis for one pair of bounds.
  function automatic scale_t predict_scale(input logic signed [cans_pkg::IN_W-1:0] lo_in,
                                           input logic signed [cans_pkg::IN_W-1:0] hi_in,
                                           input logic nf);
    longint lo, hi, span, pad, pmin, pmax, s, amin, amax;
    longint unsigned step, grow;
    scale_t r;
    lo = lo_in;
    hi = hi_in;
    r  = DEFAULT_SCALE;
    if (nf || lo < 0 || hi < lo || hi > MAXQ) return r;

    // Pad the range, then clamp it to the axis limits.
    span = hi - lo;
    if (span < ONE_Q) begin
      pad = hi / 100;
      if (pad < ONE_Q) pad = ONE_Q;
    end else begin
      pad = span / 20;
    end
    pmin = lo - pad;
    if (pmin < 0) pmin = 0;
    pmax = hi + pad;
    if (pmax > MAXQ) pmax = MAXQ;

    // Grow the step until the axis covers the padded range.
    step = nice_ceil(longint'(pmax - pmin), INTERVALS << FRAC);
    while (step <= AXIS_TOP) begin
      s    = longint'(step);
      amin = (pmin / (s << FRAC)) * s;
      amax = amin + s * INTERVALS;
      if (amax > AXIS_TOP) begin
        amax = (AXIS_TOP / s) * s;
        amin = amax - s * INTERVALS;
      end
      if (amin >= 0 && (amin << FRAC) <= pmin && (amax << FRAC) >= pmax &&
          amax <= AXIS_TOP) begin
        r.axis_min     = 20'(amin);
        r.axis_max     = 20'(amax);
        r.tick_step    = 20'(step);
        r.used_default = 1'b0;
        return r;
      end
      grow = (step > 100) ? step : 100;
      step = nice_ceil(100 * step + grow, 100);
    end
    r.axis_min     = 20'd0;
    r.axis_max     = 20'(AXIS_TOP);
    r.tick_step    = 20'((AXIS_TOP + INTERVALS - 1) / INTERVALS);
    r.used_default = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input scale_t got, input scale_t want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("MISMATCH %s at %0t: got %0d..%0d step %0d dflt %0b, want %0d..%0d step %0d dflt %0b",
               what, $realtime, got.axis_min, got.axis_max, got.tick_step, got.used_default,
               want.axis_min, want.axis_max, want.tick_step, want.used_default);
  endtask

  // Offer one item of bounds and record its expected axis once it is taken.
  task automatic send_bounds(input logic signed [cans_pkg::IN_W-1:0] lo,
                             input logic signed [cans_pkg::IN_W-1:0] hi,
                             input logic nf, input logic typed, input scale_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      bounds_ch.valid = 1'b0;
      @(negedge clk);
    end
    bounds_ch.valid      = 1'b1;
    bounds_ch.min_value  = lo;
    bounds_ch.max_value  = hi;
    bounds_ch.not_finite = nf;
    do @(posedge clk); while (!bounds_ch.ready);
    pending_scales.push_back(typed ? want : predict_scale(lo, hi, nf));
    @(negedge clk);
  endtask

  // Receiver stalls.
  always @(negedge clk) begin
    scale_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    scale_t got;
    scale_t want;
    if (!rst && scale_ch.valid && scale_ch.ready) begin
      got.axis_min     = scale_ch.axis_min;
      got.axis_max     = scale_ch.axis_max;
      got.tick_step    = scale_ch.tick_step;
      got.used_default = scale_ch.used_default;
      if (pending_scales.size() == 0) begin
        report_mismatch("unexpected item", got, NONE);
      end else begin
        want = pending_scales.pop_front();
        if (got !== want) report_mismatch("wrong axis", got, want);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((bounds_ch.valid && bounds_ch.ready) || (scale_ch.valid && scale_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int p, n, kind;
    longint hi_l, lo_l, span_l;
    logic signed [cans_pkg::IN_W-1:0] lo_v, hi_v;
    logic nf_v;

    bounds_ch.valid      = 1'b0;
    bounds_ch.min_value  = '0;
    bounds_ch.max_value  = '0;
    bounds_ch.not_finite = 1'b0;
    scale_ch.ready       = 1'b0;
    rst                  = 1'b1;

    // Directed cases: invalid inputs and extremes are typed in, the rest predicted.
    dir_rows = '{
      '{29'sd0, 29'sd25600, 1'b1, 1'b1, DEFAULT_SCALE},            // not finite
      '{-29'sd1, 29'sd25600, 1'b0, 1'b1, DEFAULT_SCALE},           // negative minimum
      '{29'sh1000_0000, 29'sh0FFF_FFFF, 1'b0, 1'b1, DEFAULT_SCALE}, // field extremes
      '{29'sd1000, 29'sd999, 1'b0, 1'b1, DEFAULT_SCALE},           // maximum below minimum
      '{29'sd0, 29'(MAXQ + 1), 1'b0, 1'b1, DEFAULT_SCALE},         // just over the limit
      '{29'sd0, 29'(FIELD_TOP), 1'b0, 1'b1, DEFAULT_SCALE},
      '{29'sd0, 29'(MAXQ), 1'b1, 1'b1, DEFAULT_SCALE},
      '{29'sd0, 29'(MAXQ), 1'b0, 1'b1, FULL_SCALE},                // full range
      '{29'sd0, 29'sd0, 1'b0, 1'b0, NONE},
      '{29'(MAXQ), 29'(MAXQ), 1'b0, 1'b0, NONE},
      '{29'sd1000, 29'sd1255, 1'b0, 1'b0, NONE},                   // span just below one
      '{29'sd1000, 29'sd1256, 1'b0, 1'b0, NONE},                   // span of exactly one
      '{29'sd2560, 29'sd3072, 1'b0, 1'b0, NONE},                   // tiny step
      '{29'sd24320, 29'sd26880, 1'b0, 1'b0, NONE},                 // span of ten
      '{29'sd0, 29'sd1, 1'b0, 1'b0, NONE},
      '{29'(MAXQ - 1), 29'(MAXQ), 1'b0, 1'b0, NONE},
      '{29'sd256, 29'sd255999744, 1'b0, 1'b0, NONE},
      '{29'sh0AAA_AAAA, 29'sh0F00_0000, 1'b0, 1'b0, NONE},
      '{29'sh0555_5555, 29'sh0EEE_EEEE, 1'b0, 1'b0, NONE},
      '{29'sd12800000, 29'sd12800000, 1'b0, 1'b0, NONE},           // padding from the maximum
      '{29'sd255, 29'sd255, 1'b0, 1'b0, NONE},
      '{29'sd25599744, 29'sd25600256, 1'b0, 1'b0, NONE}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (p = 0; p < 3; p++) begin
      // Idle mix: receiver-heavy stalls, then sender-heavy gaps, then none.
      src_idle_pct = (p == 0) ? 27 : (p == 1) ? 51 : 0;
      snk_idle_pct = (p == 0) ? 51 : (p == 1) ? 27 : 0;

      if (p == 0)
        for (n = 0; n < DIR_N; n++)
          send_bounds(dir_rows[n].lo, dir_rows[n].hi, dir_rows[n].nf, dir_rows[n].typed,
                      dir_rows[n].want);

      for (n = 0; n < RAND_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        nf_v = 1'b0;
        // Valid bounds over many scales of magnitude and span.
        hi_l = longint'($urandom) % (longint'(1) << $urandom_range(1, 28));
        if (hi_l > MAXQ || kind < 5) hi_l = MAXQ;
        span_l = longint'($urandom) % (longint'(1) << $urandom_range(0, 28));
        if (span_l > hi_l) span_l = hi_l;
        lo_l = (kind >= 5 && kind < 10) ? 0 : hi_l - span_l;
        lo_v = 29'(lo_l);
        hi_v = 29'(hi_l);
        if (kind >= 80 && kind < 88) begin
          // Raw noise over every bit, negative values included.
          lo_v = 29'($urandom);
          hi_v = 29'($urandom);
          nf_v = 1'($urandom);
        end else if (kind >= 88 && kind < 92) begin
          nf_v = 1'b1;
        end else if (kind >= 92 && kind < 96) begin
          lo_v = 29'(hi_l + 1 + $urandom_range(0, 1000));
        end else if (kind >= 96) begin
          hi_v = 29'(MAXQ + 1 + longint'($urandom) % (FIELD_TOP - MAXQ));
        end
        send_bounds(lo_v, hi_v, nf_v, 1'b0, NONE);
      end

      // Hold off until every outstanding axis has come back.
      bounds_ch.valid = 1'b0;
      while (pending_scales.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_scales.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
